@@ hdl/dds_sine_burst_generator_assert.svh @@
// Assertion macros shared by the sine burst generator modules.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef DDS_SINE_BURST_GENERATOR_ASSERT_SVH
`define DDS_SINE_BURST_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS

`define DSBG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define DSBG_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define DSBG_ASSERT(name, prop, msg)

`define DSBG_ASSERT_NEVER(name, cond, msg)

`endif

`endif

@@ hdl/dsbg_pkg.sv @@
package dsbg_pkg;

  localparam int unsigned PhaseW      = 32;
  localparam int unsigned AmpW        = 9;
  localparam int unsigned LenW        = 13;
  localparam int unsigned SampleW     = 8;
  localparam int unsigned LutIdxW     = 8;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned MaxSamples  = 4096;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);

  localparam logic [PhaseW-1:0] PhaseReset  = '0;
  localparam logic [AmpW-1:0]   AmpReset    = 9'd256;
  localparam logic [LenW-1:0]   LenReset    = 13'd1;

  typedef enum logic [CfgIdxW-1:0] {
    RegPhaseStep   = 2'd0,
    RegAmplitude   = 2'd1,
    RegBurstLength = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [PhaseW-1:0] phase_step;
    logic [LenW-1:0]   burst_length;
  } front_cfg_t;

  // One sample request passed from the phase front end to the scaling back end.
  typedef struct packed {
    logic [LutIdxW-1:0] index;
    logic               last;
  } sample_req_t;

  // floor(127.5 + 127.5*sin(2*pi*i/256))
  localparam logic [SampleW-1:0] SineLut [256] = '{
    8'd127, 8'd130, 8'd133, 8'd136, 8'd139, 8'd143, 8'd146, 8'd149,
    8'd152, 8'd155, 8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173,
    8'd176, 8'd179, 8'd182, 8'd184, 8'd187, 8'd190, 8'd193, 8'd195,
    8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213, 8'd215,
    8'd217, 8'd219, 8'd221, 8'd224, 8'd226, 8'd228, 8'd229, 8'd231,
    8'd233, 8'd235, 8'd236, 8'd238, 8'd239, 8'd241, 8'd242, 8'd244,
    8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd251,
    8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
    8'd255, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd253, 8'd253,
    8'd252, 8'd251, 8'd251, 8'd250, 8'd249, 8'd248, 8'd247, 8'd246,
    8'd245, 8'd244, 8'd242, 8'd241, 8'd239, 8'd238, 8'd236, 8'd235,
    8'd233, 8'd231, 8'd229, 8'd228, 8'd226, 8'd224, 8'd221, 8'd219,
    8'd217, 8'd215, 8'd213, 8'd210, 8'd208, 8'd205, 8'd203, 8'd200,
    8'd198, 8'd195, 8'd193, 8'd190, 8'd187, 8'd184, 8'd182, 8'd179,
    8'd176, 8'd173, 8'd170, 8'd167, 8'd164, 8'd161, 8'd158, 8'd155,
    8'd152, 8'd149, 8'd146, 8'd143, 8'd139, 8'd136, 8'd133, 8'd130,
    8'd127, 8'd124, 8'd121, 8'd118, 8'd115, 8'd111, 8'd108, 8'd105,
    8'd102, 8'd99,  8'd96,  8'd93,  8'd90,  8'd87,  8'd84,  8'd81,
    8'd78,  8'd75,  8'd72,  8'd70,  8'd67,  8'd64,  8'd61,  8'd59,
    8'd56,  8'd54,  8'd51,  8'd49,  8'd46,  8'd44,  8'd41,  8'd39,
    8'd37,  8'd35,  8'd33,  8'd30,  8'd28,  8'd26,  8'd25,  8'd23,
    8'd21,  8'd19,  8'd18,  8'd16,  8'd15,  8'd13,  8'd12,  8'd10,
    8'd9,   8'd8,   8'd7,   8'd6,   8'd5,   8'd4,   8'd3,   8'd3,
    8'd2,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,
    8'd2,   8'd3,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,
    8'd9,   8'd10,  8'd12,  8'd13,  8'd15,  8'd16,  8'd18,  8'd19,
    8'd21,  8'd23,  8'd25,  8'd26,  8'd28,  8'd30,  8'd33,  8'd35,
    8'd37,  8'd39,  8'd41,  8'd44,  8'd46,  8'd49,  8'd51,  8'd54,
    8'd56,  8'd59,  8'd61,  8'd64,  8'd67,  8'd70,  8'd72,  8'd75,
    8'd78,  8'd81,  8'd84,  8'd87,  8'd90,  8'd93,  8'd96,  8'd99,
    8'd102, 8'd105, 8'd108, 8'd111, 8'd115, 8'd118, 8'd121, 8'd124
  };

endpackage

@@ hdl/dsbg_if.sv @@
interface dsbg_in_if;
  logic valid;
  logic ready;
  logic start_req;

  modport source (output valid, output start_req, input ready);
  modport sink (input valid, input start_req, output ready);
endinterface

interface dsbg_out_if;
  logic                             valid;
  logic                             ready;
  logic [dsbg_pkg::SampleW-1:0]     sample;
  logic                             last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

interface dsbg_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dsbg_pkg::CfgIdxW-1:0]     index;
  logic [dsbg_pkg::CfgDataW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/dsbg_queue.sv @@
`include "dds_sine_burst_generator_assert.svh"

module dsbg_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  dsbg_pkg::sample_req_t push_data_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output dsbg_pkg::sample_req_t pop_data_o
);

  dsbg_pkg::sample_req_t                 mem_q [dsbg_pkg::QueueDepth];
  logic [dsbg_pkg::QueuePtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [dsbg_pkg::QueuePtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [dsbg_pkg::QueueCntW-1:0]        count_q, count_d;
  logic                                  push, pop;

  assign push_ready_o = count_q != dsbg_pkg::QueueCntW'(dsbg_pkg::QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `DSBG_ASSERT(a_count_bound, count_q <= dsbg_pkg::QueueCntW'(dsbg_pkg::QueueDepth), "queue count overflow")
  `DSBG_ASSERT(a_count_track, push && !pop |=> count_q == $past(count_q) + 1'b1, "queue count lost a push")

endmodule

@@ hdl/dsbg_front.sv @@
`include "dds_sine_burst_generator_assert.svh"

module dsbg_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dsbg_pkg::front_cfg_t   cfg_i,
  dsbg_in_if.sink                req_i,
  output logic                   push_valid_o,
  input  logic                   push_ready_i,
  output dsbg_pkg::sample_req_t  push_data_o
);

  logic [dsbg_pkg::PhaseW-1:0] phase_q, phase_d, phase_cur;
  logic [dsbg_pkg::LenW-1:0]   remaining_q, remaining_d, remaining_cur, len_sat;
  logic                        emit, accept;

  always_comb begin
    if (32'(cfg_i.burst_length) > dsbg_pkg::MaxSamples) begin
      len_sat = dsbg_pkg::LenW'(dsbg_pkg::MaxSamples);
    end else begin
      len_sat = cfg_i.burst_length;
    end
  end

  // A start takes effect on the same request that carries it.
  always_comb begin
    phase_cur     = phase_q;
    remaining_cur = remaining_q;
    if (req_i.start_req) begin
      phase_cur     = '0;
      remaining_cur = len_sat;
    end
    emit = remaining_cur != '0;
  end

  assign req_i.ready        = push_ready_i;
  assign accept             = req_i.valid && req_i.ready;
  assign push_valid_o       = req_i.valid && emit;
  assign push_data_o.index  = phase_cur[dsbg_pkg::PhaseW-1 -: dsbg_pkg::LutIdxW];
  assign push_data_o.last   = remaining_cur == dsbg_pkg::LenW'(1);

  always_comb begin
    phase_d     = phase_q;
    remaining_d = remaining_q;
    if (accept) begin
      phase_d     = emit ? phase_cur + cfg_i.phase_step : phase_cur;
      remaining_d = emit ? remaining_cur - 1'b1 : remaining_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= dsbg_pkg::PhaseReset;
      remaining_q <= '0;
    end else begin
      phase_q     <= phase_d;
      remaining_q <= remaining_d;
    end
  end

  `DSBG_ASSERT(a_last_ends_burst, accept && emit && push_data_o.last |=> remaining_q == '0, "last sample did not end the burst")

endmodule

@@ hdl/dsbg_back.sv @@
`include "dds_sine_burst_generator_assert.svh"

module dsbg_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [dsbg_pkg::AmpW-1:0]   amplitude_i,
  input  logic                        pop_valid_i,
  output logic                        pop_ready_o,
  input  dsbg_pkg::sample_req_t       pop_data_i,
  dsbg_out_if.source                  rsp_o
);

  logic [dsbg_pkg::SampleW-1:0] entry_q;
  logic                         s1_last_q, s1_valid_q;
  logic                         s1_ready, out_ready;
  logic [dsbg_pkg::SampleW-1:0] sample_q, sample_d;
  logic                         last_q, out_valid_q;
  logic signed [9:0]            diff, amp_s;
  logic signed [19:0]           prod;
  logic signed [20:0]           num;

  assign out_ready   = !out_valid_q || rsp_o.ready;
  assign s1_ready    = !s1_valid_q || out_ready;
  assign pop_ready_o = s1_ready;

  // Table stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= pop_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && pop_valid_i) begin
      entry_q   <= dsbg_pkg::SineLut[pop_data_i.index];
      s1_last_q <= pop_data_i.last;
    end
  end

  // Scale about mid-scale: floor((65280 + (2*entry - 255)*amp) / 512), clamped.
  always_comb begin
    diff  = $signed({1'b0, entry_q, 1'b0}) - 10'sd255;
    amp_s = $signed({1'b0, amplitude_i});
    prod  = 20'(diff) * 20'(amp_s);
    num   = 21'(prod) + 21'sd65280;
    if (num[20]) begin
      sample_d = '0;
    end else if (num[19:9] > 11'd255) begin
      sample_d = '1;
    end else begin
      sample_d = num[16:9];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s1_valid_q) begin
      sample_q <= sample_d;
      last_q   <= s1_last_q;
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.sample = sample_q;
  assign rsp_o.last   = last_q;

  `DSBG_ASSERT(a_s1_hold, s1_valid_q && !out_ready |=> s1_valid_q && $stable(entry_q), "table stage dropped a held sample")
  `DSBG_ASSERT_NEVER(a_no_pop_on_stall, pop_valid_i && pop_ready_o && s1_valid_q && !out_ready, "queue popped into a stalled stage")

endmodule

@@ hdl/dds_sine_burst_generator.sv @@
// Sine burst generator by direct digital synthesis. Each request on req_i is one
// tick; a tick with start_req set clears the 32-bit phase and loads the burst
// length (saturated at 4096), and every tick while samples remain yields one
// sample on rsp_o, with last set on the final one of the burst. Requests are
// taken one per clock as long as the four-entry queue between the phase front
// end and the scaling back end has room, so the sustained rate is one sample
// per cycle; a sample enters the queue at the edge that accepts its request,
// then passes the sine table stage and the scaled output register before it
// is presented. Configuration writes on cfg_i are always accepted: index 0
// phase step, 1 amplitude in Q1.8 (256 is full swing), 2 burst length; other
// indexes are ignored. Write them only while no burst is in flight.
module dds_sine_burst_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  dsbg_in_if.sink     req_i,
  dsbg_out_if.source  rsp_o,
  dsbg_cfg_if.sink    cfg_i
);

  logic [dsbg_pkg::PhaseW-1:0]  phase_step_q;
  logic [dsbg_pkg::AmpW-1:0]    amplitude_q;
  logic [dsbg_pkg::LenW-1:0]    burst_length_q;
  dsbg_pkg::front_cfg_t         front_cfg;
  logic                         push_valid, push_ready, pop_valid, pop_ready;
  dsbg_pkg::sample_req_t        push_data, pop_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q   <= dsbg_pkg::PhaseReset;
      amplitude_q    <= dsbg_pkg::AmpReset;
      burst_length_q <= dsbg_pkg::LenReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        dsbg_pkg::RegPhaseStep:   phase_step_q   <= cfg_i.data;
        dsbg_pkg::RegAmplitude:   amplitude_q    <= cfg_i.data[dsbg_pkg::AmpW-1:0];
        dsbg_pkg::RegBurstLength: burst_length_q <= cfg_i.data[dsbg_pkg::LenW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign front_cfg.phase_step   = phase_step_q;
  assign front_cfg.burst_length = burst_length_q;

  dsbg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (front_cfg),
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  dsbg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  dsbg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .amplitude_i (amplitude_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .rsp_o       (rsp_o)
  );

endmodule

@@ dv/tb_dds_sine_burst_generator.sv @@
module tb_dds_sine_burst_generator;

  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned RandomPhases  = 16;
  localparam int unsigned PhaseTicks    = 72;
  localparam int unsigned LongTicks     = 620;

  // Index 3 decodes to no register.
  localparam logic [dsbg_pkg::CfgIdxW-1:0] RegUnmapped = 2'd3;

  typedef enum int {FlowFree, FlowSendGaps, FlowRecvStall, FlowBothGaps} flow_e;

  typedef struct packed {
    logic [dsbg_pkg::SampleW-1:0] sample;
    logic                         last;
  } dac_word_t;

  localparam bit [7:0] SineRom [256] = '{
    127, 130, 133, 136, 139, 143, 146, 149, 152, 155, 158, 161, 164, 167, 170, 173,
    176, 179, 182, 184, 187, 190, 193, 195, 198, 200, 203, 205, 208, 210, 213, 215,
    217, 219, 221, 224, 226, 228, 229, 231, 233, 235, 236, 238, 239, 241, 242, 244,
    245, 246, 247, 248, 249, 250, 251, 251, 252, 253, 253, 254, 254, 254, 254, 254,
    255, 254, 254, 254, 254, 254, 253, 253, 252, 251, 251, 250, 249, 248, 247, 246,
    245, 244, 242, 241, 239, 238, 236, 235, 233, 231, 229, 228, 226, 224, 221, 219,
    217, 215, 213, 210, 208, 205, 203, 200, 198, 195, 193, 190, 187, 184, 182, 179,
    176, 173, 170, 167, 164, 161, 158, 155, 152, 149, 146, 143, 139, 136, 133, 130,
    127, 124, 121, 118, 115, 111, 108, 105, 102,  99,  96,  93,  90,  87,  84,  81,
     78,  75,  72,  70,  67,  64,  61,  59,  56,  54,  51,  49,  46,  44,  41,  39,
     37,  35,  33,  30,  28,  26,  25,  23,  21,  19,  18,  16,  15,  13,  12,  10,
      9,   8,   7,   6,   5,   4,   3,   3,   2,   1,   1,   0,   0,   0,   0,   0,
      0,   0,   0,   0,   0,   0,   1,   1,   2,   3,   3,   4,   5,   6,   7,   8,
      9,  10,  12,  13,  15,  16,  18,  19,  21,  23,  25,  26,  28,  30,  33,  35,
     37,  39,  41,  44,  46,  49,  51,  54,  56,  59,  61,  64,  67,  70,  72,  75,
     78,  81,  84,  87,  90,  93,  96,  99, 102, 105, 108, 111, 115, 118, 121, 124
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  dsbg_in_if  req_if ();
  dsbg_out_if rsp_if ();
  dsbg_cfg_if cfg_if ();

  dds_sine_burst_generator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the block's registers and burst state.
  logic [dsbg_pkg::PhaseW-1:0] step_reg;
  logic [dsbg_pkg::AmpW-1:0]   amp_reg;
  logic [dsbg_pkg::LenW-1:0]   len_reg;
  logic [dsbg_pkg::PhaseW-1:0] dds_phase;
  logic [dsbg_pkg::LenW-1:0]   samples_left;

  bit        start_q [$];
  dac_word_t pending_samples [$];

  int unsigned send_pct = 0;
  int unsigned recv_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned errors = 0;
  int unsigned ticks_sent = 0;
  int unsigned samples_seen = 0;
  int unsigned reg_writes = 0;

  function automatic logic [dsbg_pkg::SampleW-1:0] scale_sine(
    logic [7:0] entry, logic [dsbg_pkg::AmpW-1:0] amp);
    int num;
    num = 65280 + (2 * int'(entry) - 255) * int'(amp);
    if (num < 0) return '0;
    if (num / 512 > 255) return 8'd255;
    return 8'(num / 512);
  endfunction

  task automatic advance_dds(input bit start);
    if (start) begin
      dds_phase = '0;
      samples_left = (len_reg > dsbg_pkg::MaxSamples) ?
                     dsbg_pkg::LenW'(dsbg_pkg::MaxSamples) : len_reg;
    end
    if (samples_left != 0) begin
      pending_samples.push_back('{sample: scale_sine(SineRom[dds_phase[31:24]], amp_reg),
                                  last: (samples_left == 1)});
      dds_phase = dds_phase + step_reg;
      samples_left = samples_left - 1'b1;
    end
  endtask

  task automatic flag_error(input string what, input dac_word_t want, input dac_word_t got);
    if (errors < 10) begin
      $display("ERROR %s: expected sample %0d last %0b, got sample %0d last %0b",
               what, want.sample, want.last, got.sample, got.last);
    end
    errors++;
  endtask

  task automatic set_flow(input flow_e mode);
    case (mode)
      FlowFree: begin
        send_pct = 0;
        recv_pct = 0;
      end
      FlowSendGaps: begin
        send_pct = 82;
        recv_pct = 0;
      end
      FlowRecvStall: begin
        send_pct = 0;
        recv_pct = 82;
      end
      default: begin
        send_pct = 12;
        recv_pct = 12;
      end
    endcase
  endtask

  task automatic write_reg(input logic [dsbg_pkg::CfgIdxW-1:0] idx,
                           input logic [dsbg_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Returns at a falling edge once every tick is taken and every sample checked.
  task automatic drain();
    do @(negedge clk_i); while (start_q.size() != 0 || req_if.valid ||
                               pending_samples.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Request driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid     <= 1'b0;
      req_if.start_req <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      if (start_q.size() != 0 && $urandom_range(99) >= send_pct) begin
        req_if.valid     <= 1'b1;
        req_if.start_req <= start_q.pop_front();
      end else begin
        req_if.valid     <= 1'b0;
        req_if.start_req <= 1'($urandom);
      end
    end
  end

  // Sample receiver, with an occasional long hold-off to back the block up.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_pct);
      end
    end
  end

  // Monitor: tracks register writes and requests, and checks every sample.
  always @(posedge clk_i) begin
    dac_word_t got;
    dac_word_t want;
    if (!rst_ni) begin
      step_reg     = dsbg_pkg::PhaseReset;
      amp_reg      = dsbg_pkg::AmpReset;
      len_reg      = dsbg_pkg::LenReset;
      dds_phase    = '0;
      samples_left = '0;
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (cfg_if.valid && cfg_if.ready) begin
        quiet_cycles = 0;
        reg_writes++;
        case (cfg_if.index)
          dsbg_pkg::RegPhaseStep:   step_reg = cfg_if.data[dsbg_pkg::PhaseW-1:0];
          dsbg_pkg::RegAmplitude:   amp_reg  = cfg_if.data[dsbg_pkg::AmpW-1:0];
          dsbg_pkg::RegBurstLength: len_reg  = cfg_if.data[dsbg_pkg::LenW-1:0];
          default: ;
        endcase
      end
      if (req_if.valid && req_if.ready) begin
        quiet_cycles = 0;
        ticks_sent++;
        advance_dds(req_if.start_req);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        quiet_cycles = 0;
        samples_seen++;
        got = '{sample: rsp_if.sample, last: rsp_if.last};
        if (pending_samples.size() == 0) begin
          flag_error("sample with no request behind it", '0, got);
        end else begin
          want = pending_samples.pop_front();
          if (got.sample !== want.sample || got.last !== want.last) begin
            flag_error("sample mismatch", want, got);
          end
        end
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Timeout: no request moved for %0d cycles", WatchdogLimit);
        $display("dds_sine_burst_generator verification failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned run;
    int unsigned eff;
    int unsigned amp;
    int unsigned len;
    logic [dsbg_pkg::PhaseW-1:0] step;

    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.start_req = 1'b0;
    rsp_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: a tick before any start is silent, a start gives one sample.
    start_q = '{1'b0, 1'b1, 1'b0};
    drain();

    // Quarter-turn step and amplitude above unity drive both clamps; a start
    // lands in the middle of the burst and restarts it.
    write_reg(dsbg_pkg::RegPhaseStep, 32'h4000_0000);
    write_reg(dsbg_pkg::RegAmplitude, 32'd511);
    write_reg(dsbg_pkg::RegBurstLength, 32'd5);
    start_q = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    drain();

    // Unmapped index, zero length, zero amplitude, full-scale step, and a length
    // write whose upper data bits are junk.
    write_reg(RegUnmapped, 32'hFFFF_FFFF);
    write_reg(dsbg_pkg::RegPhaseStep, 32'hFFFF_FFFF);
    write_reg(dsbg_pkg::RegAmplitude, 32'hFFFF_FE00);
    write_reg(dsbg_pkg::RegBurstLength, 32'h0000_0000);
    start_q = '{1'b1, 1'b0};
    drain();
    write_reg(dsbg_pkg::RegBurstLength, 32'hFFFF_E003);
    start_q = '{1'b1, 1'b0, 1'b0, 1'b0};
    drain();

    for (int p = 0; p < RandomPhases; p++) begin
      set_flow(flow_e'(p % 4));
      case ($urandom_range(3))
        0: step = $urandom;
        1: step = $urandom_range(1 << 20);
        2: step = dsbg_pkg::PhaseW'($urandom_range(255)) << 24;
        default: step = p[0] ? 32'hFFFF_FFFF : 32'h0;
      endcase
      case ($urandom_range(4))
        0: amp = 0;
        1: amp = 256;
        2: amp = 511;
        default: amp = $urandom_range(511);
      endcase
      case ($urandom_range(9))
        0: len = 0;
        1: len = 4096;
        2: len = $urandom_range(8191, 4097);
        default: len = $urandom_range(24, 1);
      endcase
      if ($urandom_range(3) == 0) write_reg(RegUnmapped, $urandom);
      write_reg(dsbg_pkg::RegPhaseStep, step);
      write_reg(dsbg_pkg::RegAmplitude, ($urandom & ~32'h1FF) | amp);
      write_reg(dsbg_pkg::RegBurstLength, ($urandom & ~32'h1FFF) | len);
      eff = (len > dsbg_pkg::MaxSamples) ? dsbg_pkg::MaxSamples : len;
      n = 0;
      while (n < PhaseTicks) begin
        if ($urandom_range(99) < 80) begin
          // A start followed by about one burst of ticks, sometimes cut short.
          start_q.push_back(1'b1);
          n++;
          if (eff == 0) run = $urandom_range(3);
          else if ($urandom_range(5) == 0) run = $urandom_range(eff);
          else run = eff - 1 + $urandom_range(2);
          for (int k = 0; k < run && n < PhaseTicks; k++) begin
            start_q.push_back(1'b0);
            n++;
          end
        end else begin
          start_q.push_back(1'($urandom));
          n++;
        end
      end
      drain();
    end

    // An oversized length starts a long burst; the receiver holds off at its
    // start so the block backs up and stalls its input.
    set_flow(FlowFree);
    write_reg(dsbg_pkg::RegPhaseStep, $urandom);
    write_reg(dsbg_pkg::RegAmplitude, $urandom_range(256));
    write_reg(dsbg_pkg::RegBurstLength, ($urandom & ~32'h1FFF) | $urandom_range(8191, 4097));
    start_q.push_back(1'b1);
    for (int k = 0; k < LongTicks; k++) start_q.push_back(1'b0);
    hold_asked++;
    drain();

    $display("Run covered %0d ticks, %0d checked samples and %0d register writes,",
             ticks_sent, samples_seen, reg_writes);
    $display("including restarts, zero and oversized lengths, clamped amplitudes and stalls.");
    if (errors == 0 && pending_samples.size() == 0) begin
      $display("dds_sine_burst_generator verification clean");
    end else begin
      $display("Errors: %0d, samples never seen: %0d", errors, pending_samples.size());
      $display("dds_sine_burst_generator verification failed");
    end
    $finish;
  end

endmodule

@@ dds_sine_burst_generator.f @@
+incdir+hdl
hdl/dsbg_pkg.sv
hdl/dsbg_if.sv
hdl/dsbg_queue.sv
hdl/dsbg_front.sv
hdl/dsbg_back.sv
hdl/dds_sine_burst_generator.sv
dv/tb_dds_sine_burst_generator.sv
